### hdl/mbr_partition_window_translator_defines.svh
// ----------------------------------------------------------------------------
// MBR partition window translator - assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MBR_PARTITION_WINDOW_TRANSLATOR_DEFINES_SVH
`define MBR_PARTITION_WINDOW_TRANSLATOR_DEFINES_SVH

// Implication checked in the same cycle, ignored while in reset
`define MBRPWT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbrpwt: same-cycle check failed");

// A stalled beat must hold the given signal into the next cycle
`define MBRPWT_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy)) |=> \
    $stable(sig)) else $error("mbrpwt: stalled beat changed");

`endif

### hdl/mbrpwt_pkg.sv
// ----------------------------------------------------------------------------
// MBR partition window translator - package
// Codes, field layout and MBR table constants.
// ----------------------------------------------------------------------------
package mbrpwt_pkg;

  // Sector size default
  localparam int SECTOR_BYTES_DEF = 512;

  // Partition table layout
  localparam logic [8:0] TABLE_BASE  = 9'h1BE;
  localparam int         ENTRY_BYTES = 16;
  localparam int         ENTRY_COUNT = 4;
  localparam logic [8:0] TABLE_END   = 9'(TABLE_BASE + ENTRY_BYTES * ENTRY_COUNT);
  localparam int         OFF_W       = $clog2(ENTRY_BYTES);

  // Byte offsets inside one entry
  localparam logic [OFF_W-1:0] OFF_TYPE   = 4'd4;
  localparam logic [OFF_W-1:0] OFF_START0 = 4'd8;
  localparam logic [OFF_W-1:0] OFF_START3 = 4'd11;
  localparam logic [OFF_W-1:0] OFF_COUNT0 = 4'd12;
  localparam logic [OFF_W-1:0] OFF_COUNT3 = 4'd15;

  // Magic values
  localparam logic [7:0] SIG_LO    = 8'h55;
  localparam logic [7:0] SIG_HI    = 8'hAA;
  localparam logic [7:0] PART_TYPE = 8'h01;

  // Stream widths
  localparam int TDATA_W = 72;
  localparam int CFG_W   = 32;

  // Input selector (tuser)
  localparam logic FUNC_MBR_BYTE = 1'b0;
  localparam logic FUNC_ACCESS   = 1'b1;

  // Result kind (tuser)
  localparam logic KIND_INIT   = 1'b0;
  localparam logic KIND_ACCESS = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DEVICE_PRESENT = 1'b0;
  localparam logic CFG_DISK_SECTORS   = 1'b1;

endpackage

### hdl/mbr_partition_window_translator.sv
// Path: an accepted beat reaches the master side through the input register
//   and then the result register; MBR bytes other than the last give no beat.
// Throughput: one beat per cycle while the master side does not stall.
// The input register advances whenever the result register is free or drained.
// Reset (rst, synchronous): clears byte position, captured entries, offset,
//   both configuration registers and both valid flags.
// ----------------------------------------------------------------------------
// MBR partition window translator
// Parses sector 0 for a type 0x01 partition and translates/checks accesses.
// ----------------------------------------------------------------------------
module mbr_partition_window_translator
  import mbrpwt_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // slave side
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // mbr_byte[7:0], rel_lba[39:8], sector_count[71:40]
  input  logic               s_axis_tuser,  // func
  // master side
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // ok[0], part_start[32:1], abs_lba[64:33], zero pad
  output logic               m_axis_tuser   // kind
);

  localparam int POS_W = $clog2(SECTOR_BYTES);
  localparam logic [POS_W-1:0] POS_SIG_LO = POS_W'(SECTOR_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(SECTOR_BYTES - 1);

  // configuration
  logic        device_present;
  logic [31:0] disk_sectors;

  // input register
  logic        in_valid;
  logic        in_func;
  logic [7:0]  in_byte;
  logic [31:0] in_rel;
  logic [31:0] in_cnt;

  // parse state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       entry_type, entry_type_next;
  logic [31:0]      entry_start, entry_start_next;
  logic             entry_cnt_nz, entry_cnt_nz_next;
  logic [31:0]      cand_start, cand_start_next;
  logic             cand_found, cand_found_next;
  logic             sig_lo_ok, sig_lo_ok_next;
  logic [31:0]      part_offset, part_offset_next;

  // result register
  logic        out_valid;
  logic        out_kind;
  logic        out_ok;
  logic [31:0] out_part;
  logic [31:0] out_abs;

  // combinational result
  logic        res_valid;
  logic        res_kind;
  logic        res_ok;
  logic [31:0] res_part;
  logic [31:0] res_abs;

  logic advance;
  logic fire;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign fire          = in_valid && advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_present <= 1'b0;
      disk_sectors   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_PRESENT: device_present <= cfg_data[0];
        CFG_DISK_SECTORS:   disk_sectors   <= cfg_data[31:0];
        default:            ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func <= s_axis_tuser;
      in_byte <= s_axis_tdata[7:0];
      in_rel  <= s_axis_tdata[39:8];
      in_cnt  <= s_axis_tdata[71:40];
    end
  end

  // item processing
  always_comb begin
    logic [8:0]       tab_rel;
    logic [OFF_W-1:0] off;
    logic             in_table;
    logic             nz;
    logic             cnt_final;
    logic             good;
    logic [32:0]      sum;
    logic [32:0]      run_end;
    logic             bad;

    byte_position_next = byte_position;
    entry_type_next    = entry_type;
    entry_start_next   = entry_start;
    entry_cnt_nz_next  = entry_cnt_nz;
    cand_start_next    = cand_start;
    cand_found_next    = cand_found;
    sig_lo_ok_next     = sig_lo_ok;
    part_offset_next   = part_offset;

    res_valid = 1'b0;
    res_kind  = KIND_INIT;
    res_ok    = 1'b0;
    res_part  = part_offset;
    res_abs   = '0;

    tab_rel   = 9'(byte_position) - TABLE_BASE;
    off       = tab_rel[OFF_W-1:0];
    in_table  = (9'(byte_position) >= TABLE_BASE) && (9'(byte_position) < TABLE_END);
    nz        = (in_byte != 8'h00);
    cnt_final = entry_cnt_nz | nz;
    good      = device_present && sig_lo_ok && (in_byte == SIG_HI) && cand_found;

    sum     = {1'b0, in_rel} + {1'b0, part_offset};
    run_end = {1'b0, sum[31:0]} + {1'b0, in_cnt};
    if ((in_cnt == '0) || !device_present) begin
      bad = 1'b1;
    end else if (disk_sectors == '0) begin
      bad = 1'b0;
    end else begin
      // with start below the end, cnt > end - start equals start + cnt > end
      bad = sum[32] || (sum[31:0] >= disk_sectors) || (run_end > {1'b0, disk_sectors});
    end

    if (fire) begin
      if (in_func == FUNC_MBR_BYTE) begin
        // start of sector clears everything learned from the last one
        if (byte_position == '0) begin
          part_offset_next  = '0;
          cand_start_next   = '0;
          cand_found_next   = 1'b0;
          sig_lo_ok_next    = 1'b0;
          entry_type_next   = '0;
          entry_start_next  = '0;
          entry_cnt_nz_next = 1'b0;
        end

        // partition entry capture
        if (in_table) begin
          if (off == OFF_TYPE) begin
            entry_type_next = in_byte;
          end else if (off == OFF_START0) begin
            entry_start_next = {24'h0, in_byte};
          end else if ((off > OFF_START0) && (off <= OFF_START3)) begin
            entry_start_next[{off[1:0], 3'b000} +: 8] = in_byte;
          end else if (off == OFF_COUNT0) begin
            entry_cnt_nz_next = nz;
          end else if (off > OFF_COUNT0) begin
            entry_cnt_nz_next = cnt_final;
          end
          if ((off == OFF_COUNT3) && !cand_found && (entry_type == PART_TYPE) &&
              (entry_start != '0) && cnt_final) begin
            cand_start_next = entry_start;
            cand_found_next = 1'b1;
          end
        end

        if (byte_position == POS_SIG_LO) begin
          sig_lo_ok_next = (in_byte == SIG_LO);
        end

        // last byte: adopt partition and report init
        if (byte_position == POS_LAST) begin
          part_offset_next   = good ? cand_start : '0;
          res_valid          = 1'b1;
          res_kind           = KIND_INIT;
          res_ok             = good;
          res_part           = good ? cand_start : '0;
          res_abs            = '0;
          byte_position_next = '0;
        end else begin
          byte_position_next = byte_position + 1'b1;
        end
      end else begin
        // access check and translation
        res_valid = 1'b1;
        res_kind  = KIND_ACCESS;
        res_ok    = !bad;
        res_part  = part_offset;
        res_abs   = sum[31:0];
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      entry_type    <= '0;
      entry_start   <= '0;
      entry_cnt_nz  <= 1'b0;
      cand_start    <= '0;
      cand_found    <= 1'b0;
      sig_lo_ok     <= 1'b0;
      part_offset   <= '0;
    end else begin
      byte_position <= byte_position_next;
      entry_type    <= entry_type_next;
      entry_start   <= entry_start_next;
      entry_cnt_nz  <= entry_cnt_nz_next;
      cand_start    <= cand_start_next;
      cand_found    <= cand_found_next;
      sig_lo_ok     <= sig_lo_ok_next;
      part_offset   <= part_offset_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind <= res_kind;
      out_ok   <= res_ok;
      out_part <= res_part;
      out_abs  <= res_abs;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {7'h00, out_abs, out_part, out_ok};

endmodule

### hdl/mbrpwt_checker.sv
// ----------------------------------------------------------------------------
// MBR partition window translator - port checker
// Watches the master side for handshake and result-format slips.
// ----------------------------------------------------------------------------
`include "mbr_partition_window_translator_defines.svh"

module mbrpwt_checker
  import mbrpwt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser
);

  // init beat on the master side and its sector fields
  logic        init_beat;
  logic [31:0] part_field;
  logic [31:0] abs_field;

  assign init_beat  = m_axis_tvalid && (m_axis_tuser == KIND_INIT);
  assign part_field = m_axis_tdata[32:1];
  assign abs_field  = m_axis_tdata[64:33];

  // stalled result beat keeps valid and payload
  `MBRPWT_ASSERT_HOLD(a_m_valid_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid)
  `MBRPWT_ASSERT_HOLD(a_m_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata)

  // init beat carries no translated sector
  `MBRPWT_ASSERT_NOW(a_init_abs_zero, init_beat, abs_field == 32'h0)

  // failed init leaves no partition in force
  `MBRPWT_ASSERT_NOW(a_init_fail_no_part, init_beat && !m_axis_tdata[0], part_field == 32'h0)

endmodule

bind mbr_partition_window_translator mbrpwt_checker u_mbrpwt_checker (.*);

### tb/mbr_partition_window_translator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR partition window translator - testbench
// Feeds whole boot sectors and access beats into the stream port. A local
// model of the parser and the bounds check predicts every result beat, and
// the results are compared field by field in the order they were accepted.
// ----------------------------------------------------------------------------
module mbr_partition_window_translator_test;
  import mbrpwt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SECTOR_LEN  = SECTOR_BYTES_DEF;
  localparam int DRAIN_WAIT  = 4;
  localparam int MAX_PRINTS  = 40;

  // Boot sector shapes sent by the sector tests
  typedef enum int {
    SECT_VALID, SECT_BAD_SIG_LO, SECT_BAD_SIG_HI, SECT_NO_TYPE,
    SECT_ZERO_START, SECT_ZERO_COUNT, SECT_NO_DEVICE, SECT_NOISE
  } sector_kind_e;

  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [31:0] part_start;
    logic [31:0] abs_lba;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;  // mbr_byte[7:0], rel_lba[39:8], sector_count[71:40]
  logic               s_axis_tuser = 1'b0;  // func
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b1;
  logic [TDATA_W-1:0] m_axis_tdata;  // ok[0], part_start[32:1], abs_lba[64:33], zero pad
  logic               m_axis_tuser;  // kind

  // Idle rates in percent, per side
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // Local copy of the block state
  logic        dev_present = 1'b0;
  logic [31:0] disk_size = '0;
  logic [8:0]  mbr_pos = '0;
  logic [7:0]  ent_type = '0;
  logic [31:0] ent_start = '0;
  logic        ent_cnt_nz = 1'b0;
  logic [31:0] cand_start = '0;
  logic        cand_found = 1'b0;
  logic        sig_lo_seen = 1'b0;
  logic [31:0] part_offset = '0;

  result_t pending_results[$];
  logic [7:0] sector_img [SECTOR_LEN];

  mbr_partition_window_translator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Receiver stalls
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Parser and bounds check for one accepted beat
  task automatic track_beat(logic func, logic [7:0] b, logic [31:0] rel, logic [31:0] cnt);
    result_t     r;
    logic [8:0]  pos;
    logic [3:0]  off;
    logic [31:0] abs_v;
    logic        good;
    logic        fail;
    int          sh;
    if (func == FUNC_MBR_BYTE) begin
      pos = mbr_pos;
      // a new sector drops the old window
      if (pos == 0) begin
        part_offset = '0;
        cand_start  = '0;
        cand_found  = 1'b0;
        sig_lo_seen = 1'b0;
        ent_type    = '0;
        ent_start   = '0;
        ent_cnt_nz  = 1'b0;
      end
      if (pos >= TABLE_BASE && pos < TABLE_END) begin
        off = 4'(pos - TABLE_BASE);
        if (off == OFF_TYPE) begin
          ent_type = b;
        end else if (off >= OFF_START0 && off <= OFF_START3) begin
          sh = 8 * int'(off - OFF_START0);
          if (off == OFF_START0) ent_start = {24'd0, b};
          else ent_start[sh +: 8] = b;
        end else if (off >= OFF_COUNT0) begin
          if (off == OFF_COUNT0) ent_cnt_nz = (b != 0);
          else ent_cnt_nz = ent_cnt_nz | (b != 0);
          // first usable entry wins
          if (off == OFF_COUNT3 && !cand_found && ent_type == PART_TYPE &&
              ent_start != 0 && ent_cnt_nz) begin
            cand_start = ent_start;
            cand_found = 1'b1;
          end
        end
      end
      if (pos == 9'(SECTOR_LEN - 2)) sig_lo_seen = (b == SIG_LO);
      if (pos == 9'(SECTOR_LEN - 1)) begin
        good = dev_present && sig_lo_seen && (b == SIG_HI) && cand_found;
        part_offset = good ? cand_start : 32'd0;
        r.kind = KIND_INIT;
        r.ok = good;
        r.part_start = part_offset;
        r.abs_lba = '0;
        pending_results.push_back(r);
      end
      mbr_pos = pos + 9'd1;
    end else begin
      abs_v = rel + part_offset;
      if (cnt == 0 || !dev_present) fail = 1'b1;
      else if (disk_size == 0) fail = 1'b0;
      else fail = (abs_v < rel) || (abs_v >= disk_size) || (cnt > disk_size - abs_v);
      r.kind = KIND_ACCESS;
      r.ok = !fail;
      r.part_start = part_offset;
      r.abs_lba = abs_v;
      pending_results.push_back(r);
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending, tdata=%h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("kind %b, want %b", m_axis_tuser, want.kind));
        if (m_axis_tdata[0] !== want.ok)
          report_mismatch($sformatf("ok %b, want %b", m_axis_tdata[0], want.ok));
        if (m_axis_tdata[32:1] !== want.part_start)
          report_mismatch($sformatf("part_start %h, want %h", m_axis_tdata[32:1],
                                    want.part_start));
        if (m_axis_tdata[64:33] !== want.abs_lba)
          report_mismatch($sformatf("abs_lba %h, want %h", m_axis_tdata[64:33],
                                    want.abs_lba));
        if (m_axis_tdata[TDATA_W-1:65] !== '0)
          report_mismatch($sformatf("pad bits %h", m_axis_tdata[TDATA_W-1:65]));
      end
    end
  end

  // One beat on the slave side, with random gaps ahead of it
  task automatic send_beat(logic func, logic [7:0] b, logic [31:0] rel, logic [31:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tuser = 1'($urandom);
      s_axis_tdata = TDATA_W'({$urandom, $urandom, $urandom});
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = func;
    s_axis_tdata = {cnt, rel, b};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_beat(func, b, rel, cnt);
  endtask

  // Wait for every pending result plus the pipeline depth
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_DEVICE_PRESENT) dev_present = val[0];
    else disk_size = val;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(6))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(1000));
      4: return 32'($urandom_range(1, 255)) << (8 * $urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] nz_word();
    logic [31:0] w;
    w = rand_word();
    return (w == 0) ? 32'd1 : w;
  endfunction

  task automatic send_access();
    logic [31:0] rel;
    logic [31:0] cnt;
    logic [31:0] target;
    case ($urandom_range(4))
      0: begin
        rel = rand_word();
        cnt = rand_word();
      end
      1: begin
        // straddle the end of the disk
        target = disk_size - 32'($urandom_range(3));
        rel = target - part_offset;
        cnt = disk_size - target + 32'($urandom_range(2)) - 32'd1;
      end
      2: begin
        // sum crosses 2^32
        rel = 32'hFFFF_FFFF - part_offset + 32'($urandom_range(2));
        cnt = 32'($urandom_range(1, 4));
      end
      3: begin
        rel = 32'($urandom_range(64));
        cnt = 32'($urandom_range(1, 64));
      end
      default: begin
        rel = $urandom;
        cnt = ($urandom_range(1) == 0) ? 32'd0 : $urandom;
      end
    endcase
    send_beat(FUNC_ACCESS, 8'($urandom), rel, cnt);
  endtask

  task automatic put_entry(int e, logic [7:0] t, logic [31:0] st, logic [31:0] ct);
    int base;
    base = int'(TABLE_BASE) + ENTRY_BYTES * e;
    sector_img[base + int'(OFF_TYPE)] = t;
    for (int k = 0; k < 4; k++) begin
      sector_img[base + int'(OFF_START0) + k] = st[8*k +: 8];
      sector_img[base + int'(OFF_COUNT0) + k] = ct[8*k +: 8];
    end
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(2))
      0: return PART_TYPE;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic build_sector(sector_kind_e k);
    int slot;
    foreach (sector_img[i]) sector_img[i] = 8'($urandom);
    for (int e = 0; e < ENTRY_COUNT; e++) put_entry(e, pick_type(), rand_word(), rand_word());
    slot = $urandom_range(ENTRY_COUNT - 1);
    case (k)
      SECT_NO_TYPE: begin
        for (int e = 0; e < ENTRY_COUNT; e++)
          sector_img[int'(TABLE_BASE) + ENTRY_BYTES * e + int'(OFF_TYPE)] =
            PART_TYPE ^ 8'($urandom_range(1, 255));
      end
      SECT_ZERO_START: begin
        for (int e = 0; e < ENTRY_COUNT; e++) put_entry(e, PART_TYPE, 32'd0, nz_word());
      end
      SECT_ZERO_COUNT: begin
        for (int e = 0; e < ENTRY_COUNT; e++) put_entry(e, PART_TYPE, nz_word(), 32'd0);
      end
      SECT_NOISE: ;
      default: put_entry(slot, PART_TYPE, nz_word(), nz_word());
    endcase
    // signature, broken on purpose for some shapes
    if (k != SECT_NOISE) begin
      sector_img[SECTOR_LEN-2] = SIG_LO;
      sector_img[SECTOR_LEN-1] = SIG_HI;
    end
    if (k == SECT_BAD_SIG_LO) sector_img[SECTOR_LEN-2] = SIG_LO ^ 8'($urandom_range(1, 255));
    if (k == SECT_BAD_SIG_HI) sector_img[SECTOR_LEN-1] = SIG_HI ^ 8'($urandom_range(1, 255));
  endtask

  task automatic set_idling(int unsigned snd, int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // No device after reset: every access fails, any data bit aside from bit 0 ignored
  task automatic test_access_after_reset();
    send_beat(FUNC_ACCESS, 8'hFF, 32'd0, 32'd1);
    send_beat(FUNC_ACCESS, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(FUNC_ACCESS, 8'hA5, 32'd5, 32'd0);
    settle();
    write_reg(CFG_DEVICE_PRESENT, 32'hFFFF_FFFE);
    send_beat(FUNC_ACCESS, 8'h5A, 32'd7, 32'd3);
    settle();
  endtask

  // Bounds check edges with a zero offset
  task automatic test_access_bounds();
    write_reg(CFG_DEVICE_PRESENT, 32'hFFFF_FFFF);
    write_reg(CFG_DISK_SECTORS, 32'd0);
    send_beat(FUNC_ACCESS, 8'h00, 32'd0, 32'd0);
    send_beat(FUNC_ACCESS, 8'h00, 32'd0, 32'd1);
    send_beat(FUNC_ACCESS, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle();
    write_reg(CFG_DISK_SECTORS, 32'd100);
    send_beat(FUNC_ACCESS, 8'h00, 32'd99, 32'd1);
    send_beat(FUNC_ACCESS, 8'h00, 32'd100, 32'd1);
    send_beat(FUNC_ACCESS, 8'h00, 32'd0, 32'd100);
    send_beat(FUNC_ACCESS, 8'h00, 32'd0, 32'd101);
    send_beat(FUNC_ACCESS, 8'h00, 32'd50, 32'd51);
    send_beat(FUNC_ACCESS, 8'h00, 32'hFFFF_FFFF, 32'd1);
    settle();
    write_reg(CFG_DISK_SECTORS, 32'hFFFF_FFFF);
    send_beat(FUNC_ACCESS, 8'h00, 32'hFFFF_FFFE, 32'd1);
    send_beat(FUNC_ACCESS, 8'h00, 32'hFFFF_FFFE, 32'd2);
    send_beat(FUNC_ACCESS, 8'h00, 32'd0, 32'hFFFF_FFFF);
    settle();
    write_reg(CFG_DISK_SECTORS, 32'd1);
    send_beat(FUNC_ACCESS, 8'h00, 32'd0, 32'd1);
    send_beat(FUNC_ACCESS, 8'h00, 32'd0, 32'd2);
    send_beat(FUNC_ACCESS, 8'h00, 32'd1, 32'd1);
    settle();
  endtask

  // Whole sectors with accesses mixed in; even sectors carry a usable entry,
  // odd sectors take one of the failing shapes at random
  task automatic test_partition_sectors(int first, int n);
    sector_kind_e k;
    logic [31:0]  disk;
    for (int s = first; s < first + n; s++) begin
      k = (s % 2 == 0) ? SECT_VALID :
          sector_kind_e'($urandom_range(int'(SECT_BAD_SIG_LO), int'(SECT_NOISE)));
      settle();
      write_reg(CFG_DEVICE_PRESENT, {31'($urandom), 1'(k != SECT_NO_DEVICE)});
      case ($urandom_range(4))
        0: disk = 32'd0;
        1: disk = 32'hFFFF_FFFF;
        2: disk = 32'($urandom_range(1, 64));
        default: disk = $urandom;
      endcase
      write_reg(CFG_DISK_SECTORS, disk);
      build_sector(k);
      // the previous window is still in force here
      send_access();
      for (int i = 0; i < SECTOR_LEN; i++) begin
        send_beat(FUNC_MBR_BYTE, sector_img[i], $urandom, $urandom);
        // right after byte 0 the window is already cleared
        if (i == 0 || $urandom_range(99) == 0) send_access();
      end
      repeat (5) send_access();
    end
  endtask

  // Back-to-back accesses through the window left by the last sector
  task automatic test_access_stream(int n);
    repeat (n) send_access();
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_idling(36, 62);
    test_access_after_reset();
    test_access_bounds();
    test_partition_sectors(1, 1);
    set_idling(62, 36);
    test_partition_sectors(2, 1);
    set_idling(0, 0);
    test_access_stream(16);

    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
